### rtl/core/sorted_timeout_queue_core_assert.svh
// ----------------------------------------------------------------------------
// Sorted timeout queue assertion macros
// Shared concurrent assertion forms for the sorted timeout queue, clocked
// on clk and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef SORTED_TIMEOUT_QUEUE_CORE_ASSERT_SVH
`define SORTED_TIMEOUT_QUEUE_CORE_ASSERT_SVH

// The consequent holds in the same cycle as the antecedent.
`define SQC_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sorted timeout queue check failed");

// The consequent holds in the cycle after the antecedent.
`define SQC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sorted timeout queue check failed");

`endif

### rtl/core/sqc_pkg.sv
// ----------------------------------------------------------------------------
// Sorted timeout queue package
// Types and constants shared by the queue cells and the queue controller.
// ----------------------------------------------------------------------------
package sqc_pkg;

    localparam int TIME_BITS  = 32;
    localparam int DELAY_BITS = 24;
    localparam int TASK_PORT_BITS = 16;

    localparam logic [1:0] KIND_WAKEUP   = 2'd0;
    localparam logic [1:0] KIND_ACCEPTED = 2'd1;
    localparam logic [1:0] KIND_REJECTED = 2'd2;

    localparam logic CMD_ADD  = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    typedef enum logic {
        ST_IDLE,
        ST_EXPIRE
    } state_t;

    typedef struct packed {
        logic insert;
        logic pop;
    } cell_ctl_t;

endpackage

### rtl/core/sqc_cell.sv
// ----------------------------------------------------------------------------
// Sorted timeout queue cell
// Holds one deadline and task. On an insert it keeps its entry, takes the new
// entry or takes its left neighbor's entry; on a pop it takes its right
// neighbor's entry.
// ----------------------------------------------------------------------------
module sqc_cell #(
    parameter int TW = 16
) (
    input  logic                            clk,
    input  sqc_pkg::cell_ctl_t              ctl,
    input  logic [sqc_pkg::TIME_BITS-1:0]   now,
    input  logic [sqc_pkg::TIME_BITS-1:0]   new_key,
    input  logic [sqc_pkg::TIME_BITS-1:0]   new_deadline,
    input  logic [TW-1:0]                   new_task,
    input  logic                            occupied,
    input  logic                            prev_after,
    output logic                            after,
    input  logic [sqc_pkg::TIME_BITS-1:0]   left_deadline,
    input  logic [TW-1:0]                   left_task,
    input  logic [sqc_pkg::TIME_BITS-1:0]   right_deadline,
    input  logic [TW-1:0]                   right_task,
    output logic [sqc_pkg::TIME_BITS-1:0]   deadline,
    output logic [TW-1:0]                   task_id
);
    import sqc_pkg::*;

    logic [TIME_BITS-1:0] deadline_reg;
    logic [TIME_BITS-1:0] deadline_next;
    logic [TW-1:0]        task_reg;
    logic [TW-1:0]        task_next;
    logic [TIME_BITS-1:0] key;

    assign key      = deadline_reg - now;
    assign after    = prev_after && occupied && (key <= new_key);
    assign deadline = deadline_reg;
    assign task_id  = task_reg;

    always_comb
    begin
        deadline_next = deadline_reg;
        task_next     = task_reg;
        if (ctl.insert && !after)
        begin
            if (prev_after)
            begin
                deadline_next = new_deadline;
                task_next     = new_task;
            end
            else
            begin
                deadline_next = left_deadline;
                task_next     = left_task;
            end
        end
        else if (ctl.pop)
        begin
            deadline_next = right_deadline;
            task_next     = right_task;
        end
    end

    always_ff @(posedge clk)
    begin
        deadline_reg <= deadline_next;
        task_reg     <= task_next;
    end

endmodule

### rtl/core/sorted_timeout_queue_core.sv
// ----------------------------------------------------------------------------
// Sorted timeout queue core
// Millisecond clock with a deadline-sorted chain of pending timeouts.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. An add request
// (cmd 0) inserts into the sorted cell chain at that edge, or is rejected if
// the chain is full; its single result appears on the next cycle, and busy
// stays low, so adds may follow every cycle. A tick request (cmd 1) advances
// the clock and then holds busy while it checks the head of the chain and the
// n due entries leave it, one per cycle; each wakeup shows in the cycle after it leaves.
// Every result is on the result ports for exactly one cycle with strobe high
// and cannot be held off, so the receiver must take it in that cycle.
// ----------------------------------------------------------------------------
`include "sorted_timeout_queue_core_assert.svh"

module sorted_timeout_queue_core #(
    parameter int DEPTH     = 32,
    parameter int TASK_BITS = 16
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    output logic                                  busy,
    input  logic                                  cmd,
    input  logic [sqc_pkg::TASK_PORT_BITS-1:0]    task_id,
    input  logic [sqc_pkg::DELAY_BITS-1:0]        delay_ms,
    output logic                                  strobe,
    output logic [1:0]                            kind,
    output logic [sqc_pkg::TASK_PORT_BITS-1:0]    woken_task,
    output logic                                  last
);
    import sqc_pkg::*;

    localparam int TW = (TASK_BITS < TASK_PORT_BITS) ? TASK_BITS : TASK_PORT_BITS;
    localparam int CW = $clog2(DEPTH + 1);

    state_t               state_reg;
    state_t               state_next;
    logic [TIME_BITS-1:0] now_reg;
    logic [TIME_BITS-1:0] now_next;
    logic [CW-1:0]        count_reg;
    logic [CW-1:0]        count_next;

    logic                 strobe_reg;
    logic                 strobe_next;
    logic [1:0]           kind_reg;
    logic [1:0]           kind_next;
    logic [TW-1:0]        task_out_reg;
    logic [TW-1:0]        task_out_next;
    logic                 last_reg;
    logic                 last_next;

    cell_ctl_t            ctl;
    logic                 accept;
    logic                 full;
    logic                 head_due;
    logic                 second_due;
    logic [TIME_BITS-1:0] new_key;
    logic [TIME_BITS-1:0] new_deadline;
    logic [TIME_BITS-1:0] head_gap;
    logic [TIME_BITS-1:0] second_gap;
    logic [TW-1:0]        new_task;

    logic [TIME_BITS-1:0] cell_deadline [DEPTH];
    logic [TW-1:0]        cell_task     [DEPTH];
    logic [DEPTH:0]       after_chain;
    logic [DEPTH-1:0]     occupied;

    assign accept       = start && !busy;
    assign full         = (count_reg == CW'(DEPTH));
    assign new_key      = TIME_BITS'(delay_ms);
    assign new_deadline = now_reg + new_key;
    assign new_task     = task_id[TW-1:0];
    assign head_gap     = now_reg - cell_deadline[0];
    assign second_gap   = now_reg - cell_deadline[1];
    assign head_due     = occupied[0] && !head_gap[TIME_BITS-1];
    assign second_due   = occupied[1] && !second_gap[TIME_BITS-1];
    assign after_chain[0] = 1'b1;

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++)
        begin : g_cell
            logic [TIME_BITS-1:0] left_deadline;
            logic [TW-1:0]        left_task;
            logic [TIME_BITS-1:0] right_deadline;
            logic [TW-1:0]        right_task;

            assign occupied[gi] = (count_reg > CW'(gi));

            if (gi == 0)
            begin : g_head
                assign left_deadline = new_deadline;
                assign left_task     = new_task;
            end
            else
            begin : g_inner_left
                assign left_deadline = cell_deadline[gi-1];
                assign left_task     = cell_task[gi-1];
            end

            if (gi == DEPTH - 1)
            begin : g_tail
                assign right_deadline = '0;
                assign right_task     = '0;
            end
            else
            begin : g_inner_right
                assign right_deadline = cell_deadline[gi+1];
                assign right_task     = cell_task[gi+1];
            end

            sqc_cell #(
                .TW (TW)
            ) u_cell (
                .clk            (clk),
                .ctl            (ctl),
                .now            (now_reg),
                .new_key        (new_key),
                .new_deadline   (new_deadline),
                .new_task       (new_task),
                .occupied       (occupied[gi]),
                .prev_after     (after_chain[gi]),
                .after          (after_chain[gi+1]),
                .left_deadline  (left_deadline),
                .left_task      (left_task),
                .right_deadline (right_deadline),
                .right_task     (right_task),
                .deadline       (cell_deadline[gi]),
                .task_id        (cell_task[gi])
            );
        end
    endgenerate

    always_comb
    begin
        state_next    = state_reg;
        now_next      = now_reg;
        count_next    = count_reg;
        strobe_next   = 1'b0;
        kind_next     = kind_reg;
        task_out_next = task_out_reg;
        last_next     = last_reg;
        ctl.insert    = 1'b0;
        ctl.pop       = 1'b0;
        busy          = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (cmd == CMD_TICK)
                    begin
                        now_next   = now_reg + TIME_BITS'(1);
                        state_next = ST_EXPIRE;
                    end
                    else
                    begin
                        strobe_next   = 1'b1;
                        task_out_next = new_task;
                        last_next     = 1'b1;
                        if (full)
                        begin
                            kind_next = KIND_REJECTED;
                        end
                        else
                        begin
                            kind_next  = KIND_ACCEPTED;
                            ctl.insert = 1'b1;
                            count_next = count_reg + CW'(1);
                        end
                    end
                end
            end
            ST_EXPIRE:
            begin
                busy = 1'b1;
                if (head_due)
                begin
                    ctl.pop       = 1'b1;
                    count_next    = count_reg - CW'(1);
                    strobe_next   = 1'b1;
                    kind_next     = KIND_WAKEUP;
                    task_out_next = cell_task[0];
                    last_next     = !second_due;
                    if (!second_due)
                    begin
                        state_next = ST_IDLE;
                    end
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            now_reg    <= '0;
            count_reg  <= '0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            now_reg    <= now_next;
            count_reg  <= count_next;
            strobe_reg <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg     <= kind_next;
        task_out_reg <= task_out_next;
        last_reg     <= last_next;
    end

    assign strobe     = strobe_reg;
    assign kind       = kind_reg;
    assign woken_task = TASK_PORT_BITS'(task_out_reg);
    assign last       = last_reg;

    `SQC_ASSERT_SAME(a_count_bound, 1'b1, count_reg <= CW'(DEPTH))
    `SQC_ASSERT_NEXT(a_add_result, accept && (cmd == CMD_ADD), strobe && last && (kind != KIND_WAKEUP))
    `SQC_ASSERT_NEXT(a_tick_busy, accept && (cmd == CMD_TICK), busy && !strobe)
    `SQC_ASSERT_SAME(a_more_wakeups, strobe && !last, busy && (kind == KIND_WAKEUP))
    `SQC_ASSERT_SAME(a_wakeup_drains, strobe && (kind == KIND_WAKEUP), $past(count_reg) == count_reg + CW'(1))

endmodule
